// ===== hdl/rwaa_pkg.sv =====
// ----------------------------------------------------------------------------
// rwaa_pkg
// Shared codes, field widths and controller/datapath command and status types
// for the reader-writer admission arbiter.
// ----------------------------------------------------------------------------
package rwaa_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned PID_W  = 8;
  localparam int unsigned EV_W   = 2;
  localparam int unsigned WHO_W  = 8;
  localparam int unsigned RDIN_W = 5;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_ADD_READER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_WRITER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd2;

  // event codes
  localparam logic [EV_W-1:0] EV_ENTER  = 2'd0;
  localparam logic [EV_W-1:0] EV_LEAVE  = 2'd1;
  localparam logic [EV_W-1:0] EV_REJECT = 2'd2;

  localparam logic KIND_READER = 1'b0;
  localparam logic KIND_WRITER = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the request
    logic push;     // push the captured id into its wait queue
    logic reject;   // report the captured request as rejected
    logic leave;    // oldest occupant leaves
    logic admit_r;  // oldest waiting reader enters
    logic admit_w;  // oldest waiting writer enters
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_add;      // captured request adds to a wait queue
    logic is_tick;     // captured request is a tick
    logic queue_full;  // wait queue of the captured request is full
    logic occ_any;     // somebody is inside
    logic elig_r;      // a waiting reader may enter now
    logic elig_w;      // a waiting writer may enter now
  } status_t;

endpackage

// ===== hdl/rwaa_in_if.sv =====
// ----------------------------------------------------------------------------
// rwaa_in_if
// Request channel: valid/ready handshake carrying func and person_id.
// ----------------------------------------------------------------------------
interface rwaa_in_if;
  import rwaa_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PID_W-1:0]  person_id;

  modport source (output valid, output func, output person_id, input ready);
  modport sink   (input valid, input func, input person_id, output ready);
endinterface

// ===== hdl/rwaa_out_if.sv =====
// ----------------------------------------------------------------------------
// rwaa_out_if
// Event channel: valid/ready handshake carrying one admission event.
// ----------------------------------------------------------------------------
interface rwaa_out_if;
  import rwaa_pkg::*;

  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic              kind;
  logic [WHO_W-1:0]  who;
  logic [RDIN_W-1:0] readers_inside;
  logic              writer_inside;
  logic              last;

  modport source (output valid, output event_res, output kind, output who,
                  output readers_inside, output writer_inside, output last,
                  input ready);
  modport sink   (input valid, input event_res, input kind, input who,
                  input readers_inside, input writer_inside, input last,
                  output ready);
endinterface

// ===== hdl/reader_writer_admission_arbiter.sv =====
// ----------------------------------------------------------------------------
// reader_writer_admission_arbiter
// Reader-writer admission with reader preference and FIFO wait queues.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transfer: add a reader, add a writer, or a
//   tick that lets the oldest occupant leave. evt_o carries the events that
//   the request causes (entered, left, rejected), in order, with last set on
//   the final one. A request that causes no event produces no transfer.
//   Requests are handled one at a time: req_i.ready is low from the accepted
//   request until its last event has been transferred (or, without events,
//   until admission has been checked).
//   Sequence without stalls: a reject event is loaded while the request is
//   decoded, and a leave event after the occupant queue head is read; each
//   further admission passes admission check, queue head read and event
//   load, the first one after a push only once the push is done. Up to
//   QUEUE_DEPTH + 1 events per request (a leave, then a full room of
//   readers); the next request waits until all of them are transferred.
//   A stalled evt_o holds the event register and the whole sequence.
//   Reset empties all queues and clears the occupancy; the queue memories
//   are not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module reader_writer_admission_arbiter #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rwaa_in_if.sink    req_i,
  rwaa_out_if.source evt_o
);
  import rwaa_pkg::*;

  cmd_t    cmd;
  status_t status;

  rwaa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (evt_o.valid),
    .out_ready_i (evt_o.ready),
    .out_last_i  (evt_o.last),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rwaa_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .func_i           (req_i.func),
    .person_id_i      (req_i.person_id),
    .event_res_o      (evt_o.event_res),
    .kind_o           (evt_o.kind),
    .who_o            (evt_o.who),
    .readers_inside_o (evt_o.readers_inside),
    .writer_inside_o  (evt_o.writer_inside),
    .last_o           (evt_o.last)
  );

  // one request at a time: never ready while an event is pending
  a_ready_excl_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && evt_o.valid))
    else $error("request taken while an event is pending");

  // a writer inside excludes readers
  a_rw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |-> !(evt_o.writer_inside && (evt_o.readers_inside != '0)))
    else $error("writer and readers inside together");

  // a writer entry shows the writer inside
  a_writer_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.valid && (evt_o.event_res == EV_ENTER) && (evt_o.kind == KIND_WRITER))
      |-> evt_o.writer_inside)
    else $error("writer entered but not marked inside");

  // after the last event transfer req_i is ready again at once
  a_last_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.valid && evt_o.ready && evt_o.last) |=> req_i.ready)
    else $error("not ready after the final event");

endmodule

// ===== hdl/rwaa_ram.sv =====
// ----------------------------------------------------------------------------
// rwaa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwaa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rwaa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwaa_ctrl
// Sequencer: takes one request, then steps through its events one at a time,
// waiting for each event transfer before looking for the next admission.
// ----------------------------------------------------------------------------
module rwaa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              out_last_i,
  input  rwaa_pkg::status_t status_i,
  output rwaa_pkg::cmd_t    cmd_o
);
  import rwaa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LEAVE,
    S_CHECK,
    S_ADMIT_R,
    S_ADMIT_W,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;
  logic   out_valid_q;
  cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd.load = 1'b1;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_add) begin
          if (status_i.queue_full) begin
            cmd.reject = 1'b1;
            state_d    = S_OUT;
          end else begin
            cmd.push = 1'b1;
            state_d  = S_CHECK;
          end
        end else if (status_i.is_tick && status_i.occ_any) begin
          // occupant head is read during this cycle
          state_d = S_LEAVE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_LEAVE: begin
        cmd.leave = 1'b1;
        state_d   = S_OUT;
      end
      S_CHECK: begin
        if (status_i.elig_r) begin
          state_d = S_ADMIT_R;
        end else if (status_i.elig_w) begin
          state_d = S_ADMIT_W;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ADMIT_R: begin
        cmd.admit_r = 1'b1;
        state_d     = S_OUT;
      end
      S_ADMIT_W: begin
        cmd.admit_w = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = out_last_i ? S_IDLE : S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= (state_d == S_IDLE);
      out_valid_q <= (state_d == S_OUT);
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== hdl/rwaa_dpath.sv =====
// ----------------------------------------------------------------------------
// rwaa_dpath
// Wait queues, occupant queue, occupancy counters and the event register.
// ----------------------------------------------------------------------------
module rwaa_dpath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rwaa_pkg::cmd_t                       cmd_i,
  output rwaa_pkg::status_t                    status_o,
  input  logic [rwaa_pkg::FUNC_W-1:0]          func_i,
  input  logic [rwaa_pkg::PID_W-1:0]           person_id_i,
  output logic [rwaa_pkg::EV_W-1:0]            event_res_o,
  output logic                                 kind_o,
  output logic [rwaa_pkg::WHO_W-1:0]           who_o,
  output logic [rwaa_pkg::RDIN_W-1:0]          readers_inside_o,
  output logic                                 writer_inside_o,
  output logic                                 last_o
);
  import rwaa_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OW = ID_BITS + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    ptr_inc = (ptr == LAST_IDX) ? '0 : ptr + AW'(1);
  endfunction

  // captured request
  logic [FUNC_W-1:0]  func_q;
  logic [ID_BITS-1:0] id_q;
  logic [ID_BITS+PID_W-1:0] pid_ext;

  // queue pointers and counts
  logic [AW-1:0] rq_head_q, rq_head_d, rq_tail_q, rq_tail_d;
  logic [AW-1:0] wq_head_q, wq_head_d, wq_tail_q, wq_tail_d;
  logic [AW-1:0] oq_head_q, oq_head_d, oq_tail_q, oq_tail_d;
  logic [CW-1:0] rq_cnt_q, rq_cnt_d, wq_cnt_q, wq_cnt_d, oq_cnt_q, oq_cnt_d;
  logic [CW-1:0] rc_q, rc_d;
  logic          wf_q, wf_d;

  logic [ID_BITS-1:0] rq_rdata, wq_rdata;
  logic [OW-1:0]      oq_rdata, oq_wdata;
  logic               push_r, push_w, oq_we;
  logic               leave_kind;

  // event register
  logic [EV_W-1:0]    ev_q, ev_d;
  logic               kind_q, kind_d;
  logic [ID_BITS-1:0] who_id_q, who_id_d;
  logic [RDIN_W-1:0]  rdin_q;
  logic               wr_q, last_q;
  logic               ev_load, elig_next;
  logic [CW+RDIN_W-1:0]    rc_ext;
  logic [ID_BITS+WHO_W-1:0] who_ext;

  assign pid_ext = {{ID_BITS{1'b0}}, person_id_i};

  assign push_r = cmd_i.push && (func_q == FUNC_ADD_READER);
  assign push_w = cmd_i.push && (func_q == FUNC_ADD_WRITER);
  assign oq_we  = cmd_i.admit_r || cmd_i.admit_w;
  assign oq_wdata = cmd_i.admit_w ? {KIND_WRITER, wq_rdata} : {KIND_READER, rq_rdata};
  assign leave_kind = oq_rdata[OW-1];

  rwaa_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_rq_ram (
    .clk_i   (clk_i),
    .we_i    (push_r),
    .waddr_i (rq_tail_q),
    .wdata_i (id_q),
    .raddr_i (rq_head_q),
    .rdata_o (rq_rdata)
  );

  rwaa_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_wq_ram (
    .clk_i   (clk_i),
    .we_i    (push_w),
    .waddr_i (wq_tail_q),
    .wdata_i (id_q),
    .raddr_i (wq_head_q),
    .rdata_o (wq_rdata)
  );

  rwaa_ram #(.WIDTH(OW), .DEPTH(QUEUE_DEPTH)) u_oq_ram (
    .clk_i   (clk_i),
    .we_i    (oq_we),
    .waddr_i (oq_tail_q),
    .wdata_i (oq_wdata),
    .raddr_i (oq_head_q),
    .rdata_o (oq_rdata)
  );

  always_comb begin
    rq_head_d = rq_head_q;
    rq_tail_d = rq_tail_q;
    rq_cnt_d  = rq_cnt_q;
    wq_head_d = wq_head_q;
    wq_tail_d = wq_tail_q;
    wq_cnt_d  = wq_cnt_q;
    oq_head_d = oq_head_q;
    oq_tail_d = oq_tail_q;
    oq_cnt_d  = oq_cnt_q;
    rc_d      = rc_q;
    wf_d      = wf_q;
    ev_d      = EV_REJECT;
    kind_d    = func_q[0];
    who_id_d  = id_q;

    if (push_r) begin
      rq_tail_d = ptr_inc(rq_tail_q);
      rq_cnt_d  = rq_cnt_q + CW'(1);
    end
    if (push_w) begin
      wq_tail_d = ptr_inc(wq_tail_q);
      wq_cnt_d  = wq_cnt_q + CW'(1);
    end
    if (cmd_i.leave) begin
      oq_head_d = ptr_inc(oq_head_q);
      oq_cnt_d  = oq_cnt_q - CW'(1);
      if (leave_kind == KIND_READER) begin
        if (rc_q != '0) begin
          rc_d = rc_q - CW'(1);
        end
      end else begin
        wf_d = 1'b0;
      end
      ev_d     = EV_LEAVE;
      kind_d   = leave_kind;
      who_id_d = oq_rdata[ID_BITS-1:0];
    end
    if (cmd_i.admit_r) begin
      rq_head_d = ptr_inc(rq_head_q);
      rq_cnt_d  = rq_cnt_q - CW'(1);
      rc_d      = rc_q + CW'(1);
      ev_d      = EV_ENTER;
      kind_d    = KIND_READER;
      who_id_d  = rq_rdata;
    end
    if (cmd_i.admit_w) begin
      wq_head_d = ptr_inc(wq_head_q);
      wq_cnt_d  = wq_cnt_q - CW'(1);
      wf_d      = 1'b1;
      ev_d      = EV_ENTER;
      kind_d    = KIND_WRITER;
      who_id_d  = wq_rdata;
    end
    if (oq_we) begin
      oq_tail_d = ptr_inc(oq_tail_q);
      oq_cnt_d  = oq_cnt_q + CW'(1);
    end
  end

  // the event is the final one when nobody can enter from the state it leaves
  assign elig_next = (oq_cnt_d != FULL_CNT) && !wf_d &&
                     ((rq_cnt_d != '0) || ((rc_d == '0) && (wq_cnt_d != '0)));
  assign ev_load   = cmd_i.reject || cmd_i.leave || cmd_i.admit_r || cmd_i.admit_w;
  assign rc_ext    = {{RDIN_W{1'b0}}, rc_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_head_q <= '0;
      rq_tail_q <= '0;
      rq_cnt_q  <= '0;
      wq_head_q <= '0;
      wq_tail_q <= '0;
      wq_cnt_q  <= '0;
      oq_head_q <= '0;
      oq_tail_q <= '0;
      oq_cnt_q  <= '0;
      rc_q      <= '0;
      wf_q      <= 1'b0;
    end else begin
      rq_head_q <= rq_head_d;
      rq_tail_q <= rq_tail_d;
      rq_cnt_q  <= rq_cnt_d;
      wq_head_q <= wq_head_d;
      wq_tail_q <= wq_tail_d;
      wq_cnt_q  <= wq_cnt_d;
      oq_head_q <= oq_head_d;
      oq_tail_q <= oq_tail_d;
      oq_cnt_q  <= oq_cnt_d;
      rc_q      <= rc_d;
      wf_q      <= wf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      id_q   <= pid_ext[ID_BITS-1:0];
    end
    if (ev_load) begin
      ev_q     <= ev_d;
      kind_q   <= kind_d;
      who_id_q <= who_id_d;
      rdin_q   <= rc_ext[RDIN_W-1:0];
      wr_q     <= wf_d;
      last_q   <= !elig_next;
    end
  end

  always_comb begin
    status_o.is_add     = (func_q == FUNC_ADD_READER) || (func_q == FUNC_ADD_WRITER);
    status_o.is_tick    = (func_q == FUNC_TICK);
    status_o.queue_full = (func_q == FUNC_ADD_WRITER) ? (wq_cnt_q == FULL_CNT)
                                                      : (rq_cnt_q == FULL_CNT);
    status_o.occ_any    = (oq_cnt_q != '0);
    status_o.elig_r     = (oq_cnt_q != FULL_CNT) && !wf_q && (rq_cnt_q != '0);
    status_o.elig_w     = (oq_cnt_q != FULL_CNT) && !wf_q && (rc_q == '0) &&
                          (wq_cnt_q != '0);
  end

  assign who_ext          = {{WHO_W{1'b0}}, who_id_q};
  assign event_res_o      = ev_q;
  assign kind_o           = kind_q;
  assign who_o            = who_ext[WHO_W-1:0];
  assign readers_inside_o = rdin_q;
  assign writer_inside_o  = wr_q;
  assign last_o           = last_q;

endmodule
